>>> hw/rtl/mtep_pkg.sv
// ----------------------------------------------------------------------------
// MIDI track event parser package
// Shared types, codes and constants of the track event parser.
// ----------------------------------------------------------------------------
package mtep_pkg;

   localparam int unsigned LEN_W = 28;

   localparam int unsigned VLQ_MAX_BYTES = 4;
   localparam logic [2:0]  VLQ_LIMIT     = 3'(VLQ_MAX_BYTES);

   localparam logic [7:0] STATUS_CHAN_MAX = 8'hEF;
   localparam logic [7:0] STATUS_SYSEX    = 8'hF0;
   localparam logic [7:0] STATUS_ESCAPE   = 8'hF7;
   localparam logic [7:0] STATUS_META     = 8'hFF;
   localparam logic [7:0] STATUS_NONE     = 8'h00;
   localparam logic [7:0] META_END_TRACK  = 8'h2F;

   localparam logic [2:0] KIND_CHANNEL = 3'd0;
   localparam logic [2:0] KIND_META    = 3'd1;
   localparam logic [2:0] KIND_SYSEX   = 3'd2;
   localparam logic [2:0] KIND_PAYLOAD = 3'd3;
   localparam logic [2:0] KIND_SYSTEM  = 3'd4;

   typedef enum logic [2:0] {
      PH_DELTA   = 3'd0,
      PH_STATUS  = 3'd1,
      PH_DATA1   = 3'd2,
      PH_DATA2   = 3'd3,
      PH_MTYPE   = 3'd4,
      PH_LEN     = 3'd5,
      PH_PAYLOAD = 3'd6
   } phase_type;

   typedef struct packed {
      logic [2:0]       kind;
      logic [LEN_W-1:0] delta_ticks;
      logic [7:0]       status_byte;
      logic [7:0]       meta_kind;
      logic [6:0]       data_first;
      logic [6:0]       data_second;
      logic [LEN_W-1:0] payload_length;
      logic [7:0]       payload_value;
      logic             last_of_event;
      logic             track_end;
      logic             fault;
   } rsp_type;

endpackage

>>> hw/rtl/mtep_if.sv
// ----------------------------------------------------------------------------
// MIDI track event parser channels
// Valid/ready channels for track bytes and for parsed event results.
// ----------------------------------------------------------------------------
interface mtep_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] track_byte;

   modport source (output valid, output track_byte, input ready);
   modport sink   (input valid, input track_byte, output ready);
endinterface

interface mtep_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [27:0] delta_ticks;
   logic [7:0]  status_byte;
   logic [7:0]  meta_kind;
   logic [6:0]  data_first;
   logic [6:0]  data_second;
   logic [27:0] payload_length;
   logic [7:0]  payload_value;
   logic        last_of_event;
   logic        track_end;
   logic        fault;

   modport source (
      output valid, output kind, output delta_ticks, output status_byte,
      output meta_kind, output data_first, output data_second,
      output payload_length, output payload_value, output last_of_event,
      output track_end, output fault, input ready
   );
   modport sink (
      input valid, input kind, input delta_ticks, input status_byte,
      input meta_kind, input data_first, input data_second,
      input payload_length, input payload_value, input last_of_event,
      input track_end, input fault, output ready
   );
endinterface

>>> hw/rtl/mtep_in_reg.sv
// ----------------------------------------------------------------------------
// MIDI track event parser input register
// Holds one accepted track byte until the parse stage takes it.
// ----------------------------------------------------------------------------
module mtep_in_reg (
   input  logic         clock,
   input  logic         reset,
   mtep_req_if.sink     req_chan,
   input  logic         advance,
   output logic         held_valid,
   output logic [7:0]   held_byte
);
   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       take;

   assign req_chan.ready = !valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req_chan.track_byte;
      end
   end

   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;
endmodule

>>> hw/rtl/mtep_parse.sv
// ----------------------------------------------------------------------------
// MIDI track event parser decode stage
// Holds the parse state and turns one track byte into at most one result.
// ----------------------------------------------------------------------------
module mtep_parse (
   input  logic            clock,
   input  logic            reset,
   input  logic            step_valid,
   input  logic [7:0]      step_byte,
   output logic            res_valid,
   output mtep_pkg::rsp_type res
);
   import mtep_pkg::*;

   phase_type        phase_ff, phase_in;
   logic [LEN_W-1:0] vlq_acc_ff, vlq_acc_in;
   logic [1:0]       vlq_count_ff, vlq_count_in;
   logic [LEN_W-1:0] delta_ff, delta_in;
   logic [7:0]       running_ff, running_in;
   logic [7:0]       current_ff, current_in;
   logic [7:0]       meta_ff, meta_in;
   logic [6:0]       first_ff, first_in;
   logic [LEN_W-1:0] remain_ff, remain_in;

   logic [LEN_W-1:0] vlq_base;
   logic [LEN_W-1:0] vlq_value;
   logic             vlq_more;
   logic             one_data_run;
   logic             one_data_cur;
   logic [LEN_W-1:0] remain_dec;
   logic             is_data;
   logic             is_chan_status;
   logic             is_sysex;
   logic             produce;
   logic             is_meta;
   logic             has_len;

   assign vlq_base     = (vlq_count_ff == 2'd0) ? '0 : vlq_acc_ff;
   assign vlq_value    = {vlq_base[LEN_W-8:0], step_byte[6:0]};
   assign vlq_more     = step_byte[7] && (({1'b0, vlq_count_ff} + 3'd1) < VLQ_LIMIT);
   assign one_data_run = (running_ff[7:5] == 3'b110);
   assign one_data_cur = (current_ff[7:5] == 3'b110);
   assign remain_dec   = remain_ff - LEN_W'(1);
   assign is_data      = !step_byte[7];
   assign is_chan_status = (step_byte <= STATUS_CHAN_MAX);
   assign is_sysex     = (step_byte == STATUS_SYSEX) || (step_byte == STATUS_ESCAPE);

   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_STATUS: begin
            if (is_data) begin
               if (running_ff == STATUS_NONE || one_data_run) begin
                  phase_in = PH_DELTA;
               end else begin
                  phase_in = PH_DATA2;
               end
            end else if (is_chan_status) begin
               phase_in = PH_DATA1;
            end else if (step_byte == STATUS_META) begin
               phase_in = PH_MTYPE;
            end else if (is_sysex) begin
               phase_in = PH_LEN;
            end else begin
               phase_in = PH_DELTA;
            end
         end
         PH_DATA1: phase_in = one_data_cur ? PH_DELTA : PH_DATA2;
         PH_DATA2: phase_in = PH_DELTA;
         PH_MTYPE: phase_in = PH_LEN;
         PH_LEN: begin
            if (!vlq_more) begin
               phase_in = (vlq_value == '0) ? PH_DELTA : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            if (remain_dec == '0) begin
               phase_in = PH_DELTA;
            end
         end
         default: phase_in = vlq_more ? PH_DELTA : PH_STATUS;
      endcase
   end

   always_comb begin
      vlq_acc_in   = vlq_acc_ff;
      vlq_count_in = vlq_count_ff;
      delta_in     = delta_ff;
      running_in   = running_ff;
      current_in   = current_ff;
      meta_in      = meta_ff;
      first_in     = first_ff;
      remain_in    = remain_ff;
      case (phase_ff)
         PH_STATUS: begin
            if (is_data) begin
               if (running_ff != STATUS_NONE) begin
                  current_in = running_ff;
                  if (!one_data_run) begin
                     first_in = step_byte[6:0];
                  end
               end
            end else begin
               current_in = step_byte;
               if (is_chan_status) begin
                  running_in = step_byte;
               end else if (step_byte != STATUS_META) begin
                  meta_in = '0;
                  if (is_sysex) begin
                     vlq_count_in = '0;
                  end
               end
            end
         end
         PH_DATA1: begin
            if (!one_data_cur) begin
               first_in = step_byte[6:0];
            end
         end
         PH_DATA2: begin
         end
         PH_MTYPE: begin
            meta_in      = step_byte;
            vlq_count_in = '0;
         end
         PH_LEN: begin
            vlq_acc_in   = vlq_value;
            vlq_count_in = vlq_more ? (vlq_count_ff + 2'd1) : 2'd0;
            if (!vlq_more) begin
               remain_in = vlq_value;
            end
         end
         PH_PAYLOAD: remain_in = remain_dec;
         default: begin
            vlq_acc_in   = vlq_value;
            vlq_count_in = vlq_more ? (vlq_count_ff + 2'd1) : 2'd0;
            if (!vlq_more) begin
               delta_in = vlq_value;
            end
         end
      endcase
   end

   always_comb begin
      produce           = 1'b0;
      res               = '0;
      res.delta_ticks   = delta_ff;
      case (phase_ff)
         PH_STATUS: begin
            if (is_data) begin
               if (running_ff == STATUS_NONE) begin
                  produce           = 1'b1;
                  res.kind          = KIND_CHANNEL;
                  res.status_byte   = STATUS_NONE;
                  res.data_first    = step_byte[6:0];
                  res.last_of_event = 1'b1;
                  res.fault         = 1'b1;
               end else if (one_data_run) begin
                  produce           = 1'b1;
                  res.kind          = KIND_CHANNEL;
                  res.status_byte   = running_ff;
                  res.data_first    = step_byte[6:0];
                  res.last_of_event = 1'b1;
               end
            end else if (!is_chan_status && step_byte != STATUS_META && !is_sysex) begin
               produce           = 1'b1;
               res.kind          = KIND_SYSTEM;
               res.status_byte   = step_byte;
               res.last_of_event = 1'b1;
            end
         end
         PH_DATA1: begin
            if (one_data_cur) begin
               produce           = 1'b1;
               res.kind          = KIND_CHANNEL;
               res.status_byte   = current_ff;
               res.data_first    = step_byte[6:0];
               res.last_of_event = 1'b1;
            end
         end
         PH_DATA2: begin
            produce           = 1'b1;
            res.kind          = KIND_CHANNEL;
            res.status_byte   = current_ff;
            res.data_first    = first_ff;
            res.data_second   = step_byte[6:0];
            res.last_of_event = 1'b1;
         end
         PH_LEN: begin
            if (!vlq_more) begin
               produce            = 1'b1;
               res.kind           = (current_ff == STATUS_META) ? KIND_META : KIND_SYSEX;
               res.status_byte    = current_ff;
               res.payload_length = vlq_value;
               res.last_of_event  = (vlq_value == '0);
            end
         end
         PH_PAYLOAD: begin
            produce            = 1'b1;
            res.kind           = KIND_PAYLOAD;
            res.status_byte    = current_ff;
            res.payload_length = vlq_acc_ff;
            res.payload_value  = step_byte;
            res.last_of_event  = (remain_dec == '0);
         end
         default: begin
         end
      endcase
      is_meta = (res.status_byte == STATUS_META) &&
                (res.kind == KIND_META || res.kind == KIND_PAYLOAD);
      has_len = (res.kind == KIND_META || res.kind == KIND_SYSEX ||
                 res.kind == KIND_PAYLOAD);
      if (is_meta) begin
         res.meta_kind = meta_ff;
      end
      if (!has_len) begin
         res.payload_length = '0;
      end
      res.track_end = res.last_of_event && is_meta && (meta_ff == META_END_TRACK);
   end

   assign res_valid = step_valid && produce;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_DELTA;
         vlq_acc_ff   <= '0;
         vlq_count_ff <= '0;
         delta_ff     <= '0;
         running_ff   <= '0;
         current_ff   <= '0;
         meta_ff      <= '0;
         first_ff     <= '0;
         remain_ff    <= '0;
      end else if (step_valid) begin
         phase_ff     <= phase_in;
         vlq_acc_ff   <= vlq_acc_in;
         vlq_count_ff <= vlq_count_in;
         delta_ff     <= delta_in;
         running_ff   <= running_in;
         current_ff   <= current_in;
         meta_ff      <= meta_in;
         first_ff     <= first_in;
         remain_ff    <= remain_in;
      end
   end
endmodule

>>> hw/rtl/mtep_out_reg.sv
// ----------------------------------------------------------------------------
// MIDI track event parser result register
// Holds one result until the downstream side takes the transfer.
// ----------------------------------------------------------------------------
module mtep_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  mtep_pkg::rsp_type load_data,
   output logic              free,
   mtep_rsp_if.source        rsp_chan
);
   import mtep_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   assign free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_chan.valid          = valid_ff;
   assign rsp_chan.kind           = data_ff.kind;
   assign rsp_chan.delta_ticks    = data_ff.delta_ticks;
   assign rsp_chan.status_byte    = data_ff.status_byte;
   assign rsp_chan.meta_kind      = data_ff.meta_kind;
   assign rsp_chan.data_first     = data_ff.data_first;
   assign rsp_chan.data_second    = data_ff.data_second;
   assign rsp_chan.payload_length = data_ff.payload_length;
   assign rsp_chan.payload_value  = data_ff.payload_value;
   assign rsp_chan.last_of_event  = data_ff.last_of_event;
   assign rsp_chan.track_end      = data_ff.track_end;
   assign rsp_chan.fault          = data_ff.fault;
endmodule

>>> hw/rtl/midi_track_event_parser_top.sv
// ----------------------------------------------------------------------------
// MIDI track event parser
// Splits a track chunk body into channel, meta, sysex, system and payload results.
// ----------------------------------------------------------------------------
// The parser takes one track byte per clock cycle while the result channel
// keeps up. A byte is captured in an input register and decoded against the
// parse state once the result register is free, and any result it causes is
// registered in the result register and shown on the result channel. The
// parse state is updated as each byte is decoded; a stalled result channel
// holds the input side once both the input and result registers are full.
// Delta times and lengths are decoded as variable-length numbers of up to four bytes.
module midi_track_event_parser_top (
   input  logic       clock,
   input  logic       reset,
   mtep_req_if.sink   req_chan,
   mtep_rsp_if.source rsp_chan
);
   import mtep_pkg::*;

   logic       held_valid;
   logic [7:0] held_byte;
   logic       advance;
   logic       res_valid;
   rsp_type    res;
   logic       out_free;

   assign advance = held_valid && out_free;

   mtep_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .advance    (advance),
      .held_valid (held_valid),
      .held_byte  (held_byte)
   );

   mtep_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .step_valid (advance),
      .step_byte  (held_byte),
      .res_valid  (res_valid),
      .res        (res)
   );

   mtep_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (res_valid),
      .load_data (res),
      .free      (out_free),
      .rsp_chan  (rsp_chan)
   );

`ifndef NO_ASSERTIONS
   a_fault_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.fault |->
         rsp_chan.kind == KIND_CHANNEL && rsp_chan.status_byte == STATUS_NONE &&
         rsp_chan.last_of_event)
      else $error("fault result has wrong shape");

   a_track_end: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.track_end |->
         rsp_chan.last_of_event && rsp_chan.meta_kind == META_END_TRACK &&
         rsp_chan.status_byte == STATUS_META)
      else $error("end of track flag on a non-meta result");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.kind <= KIND_SYSTEM)
      else $error("result kind out of range");

   a_held_byte: assert property (@(posedge clock) disable iff (reset)
      held_valid && !advance |=> held_valid && $stable(held_byte))
      else $error("pending input byte lost or overwritten");
`endif
endmodule
